[design/air_pkg.sv]
// Shared types and constants for the AArch64 instruction relocator.
// No dependencies.

package air_pkg;

  localparam logic [31:0] W_LDR_X16_LIT = 32'h5800_0050;
  localparam logic [31:0] W_BR_X16      = 32'hD61F_0200;
  localparam logic [31:0] W_B_SKIP12    = 32'h1400_0003;
  localparam logic [31:0] W_LDR_X30_LIT = 32'h5800_00BE;
  localparam logic [31:0] W_LDR_XD_LIT  = 32'h5800_0040;
  localparam logic [31:0] W_LDR_W_X16   = 32'hB940_0200;
  localparam logic [31:0] W_LDR_X_X16   = 32'hF940_0200;
  localparam logic [31:0] W_LDRSW_X16   = 32'hB980_0200;
  localparam logic [31:0] W_PRFM_X16    = 32'hF980_0200;
  localparam logic [31:0] W_LDR_S_X16   = 32'hBD40_0200;
  localparam logic [31:0] W_LDR_D_X16   = 32'hFD40_0200;
  localparam logic [31:0] W_LDR_Q_X16   = 32'h3DC0_0200;
  localparam logic [31:0] W_NOP         = 32'hD503_201F;

  typedef logic [2:0] kind_t;

  localparam kind_t K_PASS = 3'd0;
  localparam kind_t K_BAD  = 3'd1;
  localparam kind_t K_ADR  = 3'd2;
  localparam kind_t K_LIT  = 3'd3;
  localparam kind_t K_B    = 3'd4;
  localparam kind_t K_BL   = 3'd5;
  localparam kind_t K_COND = 3'd6;

  typedef logic [2:0] word_idx_t;

  // one classified request waiting for emission
  typedef struct packed {
    kind_t       kind;
    logic [31:0] xw;
    logic [63:0] target;
    logic [63:0] ret;
  } relo_item_t;

endpackage

[design/air_front.sv]
// Front end: classifies an instruction and computes its absolute target.
// Depends on air_pkg.

module air_front (
  input  logic              [31:0] instr_word,
  input  logic              [63:0] instr_addr,
  output air_pkg::relo_item_t      item
);
  import air_pkg::*;

  logic [31:0] w;
  logic [63:0] base;
  logic [63:0] offset;
  logic [4:0]  rt;
  logic [1:0]  opc;

  assign w   = instr_word;
  assign rt  = w[4:0];
  assign opc = w[31:30];

  always_comb begin
    item.kind = K_PASS;
    item.xw   = w;
    base      = instr_addr;
    offset    = {{43{w[23]}}, w[23:5], 2'b00};
    priority if (w[28:24] == 5'b10000) begin
      item.kind = K_ADR;
      item.xw   = W_LDR_XD_LIT | {27'd0, rt};
      if (w[31]) begin
        base   = {instr_addr[63:12], 12'h000};
        offset = {{31{w[23]}}, w[23:5], w[30:29], 12'h000};
      end else begin
        offset = {{43{w[23]}}, w[23:5], w[30:29]};
      end
    end else if (w[29:24] == 6'b011000) begin
      item.kind = K_LIT;
      unique case (opc)
        2'd0: item.xw = W_LDR_W_X16 | {27'd0, rt};
        2'd1: item.xw = W_LDR_X_X16 | {27'd0, rt};
        2'd2: item.xw = W_LDRSW_X16 | {27'd0, rt};
        default: item.xw = W_PRFM_X16 | {27'd0, rt};
      endcase
    end else if (w[29:24] == 6'b011100) begin
      item.kind = K_LIT;
      unique case (opc)
        2'd0: item.xw = W_LDR_S_X16 | {27'd0, rt};
        2'd1: item.xw = W_LDR_D_X16 | {27'd0, rt};
        2'd2: item.xw = W_LDR_Q_X16 | {27'd0, rt};
        default: begin
          item.kind = K_BAD;
          item.xw   = 32'd0;
        end
      endcase
    end else if (w[30:26] == 5'b00101) begin
      item.kind = w[31] ? K_BL : K_B;
      offset    = {{36{w[25]}}, w[25:0], 2'b00};
    end else if (w[31:24] == 8'h54) begin
      item.kind = K_COND;
      if (w[3:1] == 3'b111) begin
        item.xw = W_NOP;
      end else begin
        item.xw = ((w & ~32'h00FF_FFE0) ^ 32'd1) | 32'h0000_00A0;
      end
    end else if (w[30:25] == 6'b011010) begin
      item.kind = K_COND;
      item.xw   = ((w ^ 32'h0100_0000) & ~32'h00FF_FFE0) | 32'h0000_00A0;
    end else if (w[30:25] == 6'b011011) begin
      item.kind = K_COND;
      item.xw   = ((w ^ 32'h0100_0000) & ~32'h0007_FFE0) | 32'h0000_00A0;
      offset    = {{48{w[18]}}, w[18:5], 2'b00};
    end else begin
      item.kind = K_PASS;
    end
    item.target = base + offset;
    item.ret    = instr_addr + 64'd4;
  end

endmodule

[design/air_queue.sv]
// Short request queue between the front and back ends.
// Depends on air_pkg.

module air_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  air_pkg::relo_item_t push_item,
  output logic                full,
  output logic                head_valid,
  output air_pkg::relo_item_t head_item,
  input  logic                pop
);
  import air_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  relo_item_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/air_back.sv]
// Back end: steps through a request's run one word a cycle, unless result_stall holds it, into the output register.
// Depends on air_pkg.

module air_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  air_pkg::relo_item_t head_item,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output logic         [31:0] out_word,
  output logic                is_last,
  output logic                bad_form
);
  import air_pkg::*;

  word_idx_t   idx;
  word_idx_t   last_idx;
  logic [31:0] word;
  logic        load;
  logic        at_last;

  always_comb begin
    unique case (head_item.kind)
      K_ADR, K_B:  last_idx = 3'd3;
      K_LIT, K_COND: last_idx = 3'd4;
      K_BL:        last_idx = 3'd6;
      default:     last_idx = 3'd0;
    endcase
  end

  always_comb begin
    word = head_item.xw;
    unique case (head_item.kind)
      K_ADR: begin
        unique case (idx)
          3'd0: word = head_item.xw;
          3'd1: word = W_B_SKIP12;
          3'd2: word = head_item.target[31:0];
          default: word = head_item.target[63:32];
        endcase
      end
      K_LIT: begin
        unique case (idx)
          3'd0: word = W_LDR_X16_LIT;
          3'd1: word = W_B_SKIP12;
          3'd2: word = head_item.target[31:0];
          3'd3: word = head_item.target[63:32];
          default: word = head_item.xw;
        endcase
      end
      K_B: begin
        unique case (idx)
          3'd0: word = W_LDR_X16_LIT;
          3'd1: word = W_BR_X16;
          3'd2: word = head_item.target[31:0];
          default: word = head_item.target[63:32];
        endcase
      end
      K_BL: begin
        unique case (idx)
          3'd0: word = W_LDR_X30_LIT;
          3'd1: word = W_LDR_X16_LIT;
          3'd2: word = W_BR_X16;
          3'd3: word = head_item.target[31:0];
          3'd4: word = head_item.target[63:32];
          3'd5: word = head_item.ret[31:0];
          default: word = head_item.ret[63:32];
        endcase
      end
      K_COND: begin
        unique case (idx)
          3'd0: word = head_item.xw;
          3'd1: word = W_LDR_X16_LIT;
          3'd2: word = W_BR_X16;
          3'd3: word = head_item.target[31:0];
          default: word = head_item.target[63:32];
        endcase
      end
      default: word = head_item.xw;
    endcase
  end

  assign load    = head_valid && (!result_valid || !result_stall);
  assign at_last = (idx == last_idx);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= word;
      is_last  <= at_last;
      bad_form <= (head_item.kind == K_BAD);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        idx          <= at_last ? '0 : idx + 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

[design/aarch64_insn_relocator_unit.sv]
// Top level of the AArch64 PC-relative instruction relocator.
// Depends on air_pkg, air_front, air_queue and air_back.
//
//   channel  valid         stall         payload
//   -------  ------------  ------------  ------------------------------
//   in       instr_valid   instr_stall   instr_word, instr_addr
//   out      result_valid  result_stall  out_word, is_last, bad_form
//
// The back end emits one word per cycle while result_stall does not hold it; a request
// emits 1, 4, 5 or 7 words (BL is 7) through the single output register.
// A request is decoded and its target added in the cycle it is accepted and
// enters a QUEUE_DEPTH-entry queue; from the queue head its words are then registered.
// instr_stall is high only while the queue is full. Synchronous reset empties
// the queue and the output register; no clearing pass.

module aarch64_insn_relocator_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        instr_valid,
  output logic        instr_stall,
  input  logic [31:0] instr_word,
  input  logic [63:0] instr_addr,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] out_word,
  output logic        is_last,
  output logic        bad_form
);
  import air_pkg::*;

  relo_item_t front_item;
  relo_item_t head_item;
  logic       full;
  logic       head_valid;
  logic       pop;
  logic       push;

  assign instr_stall = full;
  assign push        = instr_valid && !full;

  air_front u_front (
    .instr_word (instr_word),
    .instr_addr (instr_addr),
    .item       (front_item)
  );

  air_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (front_item),
    .full       (full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  air_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_word     (out_word),
    .is_last      (is_last),
    .bad_form     (bad_form)
  );

endmodule
